>>> hw/rtl/jfi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfi_pkg
// Shared types and constants for the Jain fairness index core.
// ----------------------------------------------------------------------------
package jfi_pkg;

  // field widths
  localparam int BYTES_W   = 41;   // signed flow byte count
  localparam int MAG_W     = 40;   // magnitude of a counted flow
  localparam int ID_W      = 16;
  localparam int COUNT_W   = 13;
  localparam int INDEX_W   = 17;
  localparam int SHARE_W   = 15;

  // squaring split: x = xh * 2^XL_W + xl
  localparam int XL_W      = 24;
  localparam int XH_W      = MAG_W - XL_W;
  localparam int SQS_W     = 96;   // sum of squares, wraps mod 2^96

  // hog share = hog * 100 * 256 / sum, quotient below 2^SHARE_QW
  localparam int SHARE_QW  = 15;
  localparam int SHARE_NW  = MAG_W + SHARE_QW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_DEN_LD,
    ST_DEN_RUN,
    ST_SQ_LD,
    ST_SQ_RUN,
    ST_IDX_LD,
    ST_IDX_RUN,
    ST_SHR_LD,
    ST_SHR_RUN,
    ST_LOAD
  } state_t;

  typedef enum logic {
    MSEL_DEN,   // n * sum of squares
    MSEL_SQ     // sum * sum
  } mul_sel_t;

  typedef enum logic {
    DSEL_IDX,   // fairness index
    DSEL_SHARE  // hog share
  } div_sel_t;

  typedef struct packed {
    logic     absorb;
    logic     mul_ld;
    mul_sel_t mul_sel;
    logic     mul_step;
    logic     den_cap;
    logic     div_ld;
    div_sel_t div_sel;
    logic     div_step;
    logic     idx_cap;
    logic     res_ld;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic mul_done;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

>>> hw/rtl/jain_fairness_index_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jain_fairness_index_core
// Jain fairness index and largest-flow share over a set of flows.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in_     | input     | in_valid/in_ready  | flow_bytes, flow_id, last_flow
//  out_    | output    | out_valid/out_ready| flow_count, fairness_index,
//          |           |                    | peak_bytes, hog_flow, hog_share,
//          |           |                    | too_many_flows
//
//  Non-last flows: one transaction per cycle, in_ready stays high.
//  Last flow: in_ready drops for the report; the two shift-add multiplies
//    and the bit-per-cycle divider set how long it stays low.
//    An empty set skips the arithmetic.
//  Reset (rst_n low, synchronous) clears all counters and the result valid.
//  The result sits in an output register; new flows are taken while it waits.
//  A second report stalls in its final state until the previous one is taken.
//
// ----------------------------------------------------------------------------
module jain_fairness_index_core #(
  parameter int MAX_FLOWS       = 4096,
  parameter int INDEX_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // flow input
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [jfi_pkg::BYTES_W-1:0]  in_flow_bytes,
  input  logic        [jfi_pkg::ID_W-1:0]     in_flow_id,
  input  logic                                in_last_flow,
  // report output
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [jfi_pkg::COUNT_W-1:0]  out_flow_count,
  output logic        [jfi_pkg::INDEX_W-1:0]  out_fairness_index,
  output logic        [jfi_pkg::MAG_W-1:0]    out_peak_bytes,
  output logic        [jfi_pkg::ID_W-1:0]     out_hog_flow,
  output logic        [jfi_pkg::SHARE_W-1:0]  out_hog_share,
  output logic                                out_too_many_flows
);

  jfi_pkg::cmd_t    cmd;
  jfi_pkg::status_t sts;

  // sequencer: accept phase, then DEN mul -> SQ mul -> index div -> share div
  jfi_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_flow (in_last_flow),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // accumulators, squarer, multiplier, divider, result register
  jfi_datapath #(
    .MAX_FLOWS       (MAX_FLOWS),
    .INDEX_FRAC_BITS (INDEX_FRAC_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_flow_bytes      (in_flow_bytes),
    .in_flow_id         (in_flow_id),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_flow_count     (out_flow_count),
    .out_fairness_index (out_fairness_index),
    .out_peak_bytes     (out_peak_bytes),
    .out_hog_flow       (out_hog_flow),
    .out_hog_share      (out_hog_share),
    .out_too_many_flows (out_too_many_flows)
  );

`ifndef SYNTH
  // a last-flow transaction always starts a report, so input must close
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_flow) |=> !in_ready)
    else $error("input still open after last flow");

  // an empty set reports all zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_flow_count == '0) && (out_peak_bytes == '0)) |->
      ((out_fairness_index == '0) && (out_hog_share == '0)))
    else $error("empty report with nonzero fields");
`endif

endmodule

>>> hw/rtl/jfi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfi_ctrl
// Sequencer: accepts flows, then walks the report through multiply and
// divide phases and hands the result to the output register.
// ----------------------------------------------------------------------------
module jfi_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last_flow,
  output logic             in_ready,
  input  jfi_pkg::status_t sts,
  output jfi_pkg::cmd_t    cmd
);

  jfi_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jfi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      jfi_pkg::ST_IDLE: begin
        if (in_valid && in_last_flow) state_nxt = jfi_pkg::ST_DRAIN;
      end
      jfi_pkg::ST_DRAIN: begin
        state_nxt = sts.count_zero ? jfi_pkg::ST_LOAD : jfi_pkg::ST_DEN_LD;
      end
      jfi_pkg::ST_DEN_LD:  state_nxt = jfi_pkg::ST_DEN_RUN;
      jfi_pkg::ST_DEN_RUN: begin
        if (sts.mul_done) state_nxt = jfi_pkg::ST_SQ_LD;
      end
      jfi_pkg::ST_SQ_LD:   state_nxt = jfi_pkg::ST_SQ_RUN;
      jfi_pkg::ST_SQ_RUN: begin
        if (sts.mul_done) state_nxt = jfi_pkg::ST_IDX_LD;
      end
      jfi_pkg::ST_IDX_LD:  state_nxt = jfi_pkg::ST_IDX_RUN;
      jfi_pkg::ST_IDX_RUN: begin
        if (sts.div_done) state_nxt = jfi_pkg::ST_SHR_LD;
      end
      jfi_pkg::ST_SHR_LD:  state_nxt = jfi_pkg::ST_SHR_RUN;
      jfi_pkg::ST_SHR_RUN: begin
        if (sts.div_done) state_nxt = jfi_pkg::ST_LOAD;
      end
      jfi_pkg::ST_LOAD: begin
        if (!sts.out_busy) state_nxt = jfi_pkg::ST_IDLE;
      end
      default: state_nxt = jfi_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.mul_sel  = jfi_pkg::MSEL_DEN;
    cmd.div_sel  = jfi_pkg::DSEL_IDX;
    unique case (state_r)
      jfi_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.absorb = in_valid;
      end
      jfi_pkg::ST_DRAIN: ;
      jfi_pkg::ST_DEN_LD: begin
        cmd.mul_ld  = 1'b1;
        cmd.mul_sel = jfi_pkg::MSEL_DEN;
      end
      jfi_pkg::ST_DEN_RUN: begin
        cmd.mul_step = !sts.mul_done;
        cmd.den_cap  = sts.mul_done;
      end
      jfi_pkg::ST_SQ_LD: begin
        cmd.mul_ld  = 1'b1;
        cmd.mul_sel = jfi_pkg::MSEL_SQ;
      end
      jfi_pkg::ST_SQ_RUN: begin
        cmd.mul_step = !sts.mul_done;
      end
      jfi_pkg::ST_IDX_LD: begin
        cmd.div_ld  = 1'b1;
        cmd.div_sel = jfi_pkg::DSEL_IDX;
      end
      jfi_pkg::ST_IDX_RUN: begin
        cmd.div_step = !sts.div_done;
        cmd.idx_cap  = sts.div_done;
      end
      jfi_pkg::ST_SHR_LD: begin
        cmd.div_ld  = 1'b1;
        cmd.div_sel = jfi_pkg::DSEL_SHARE;
      end
      jfi_pkg::ST_SHR_RUN: begin
        cmd.div_step = !sts.div_done;
      end
      jfi_pkg::ST_LOAD: begin
        cmd.res_ld = !sts.out_busy;
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/jfi_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfi_datapath
// Flow accumulators, pipelined squarer, shift-add multiplier, restoring
// divider and the result register.
// ----------------------------------------------------------------------------
module jfi_datapath #(
  parameter int MAX_FLOWS       = 4096,
  parameter int INDEX_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [jfi_pkg::BYTES_W-1:0]  in_flow_bytes,
  input  logic        [jfi_pkg::ID_W-1:0]     in_flow_id,
  input  jfi_pkg::cmd_t                       cmd,
  output jfi_pkg::status_t                    sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic        [jfi_pkg::COUNT_W-1:0]  out_flow_count,
  output logic        [jfi_pkg::INDEX_W-1:0]  out_fairness_index,
  output logic        [jfi_pkg::MAG_W-1:0]    out_peak_bytes,
  output logic        [jfi_pkg::ID_W-1:0]     out_hog_flow,
  output logic        [jfi_pkg::SHARE_W-1:0]  out_hog_share,
  output logic                                out_too_many_flows
);

  localparam int CW   = $clog2(MAX_FLOWS + 1);
  localparam int SUMW = jfi_pkg::MAG_W + CW;
  localparam int PW   = (jfi_pkg::SQS_W + CW > 2 * SUMW) ? jfi_pkg::SQS_W + CW : 2 * SUMW;
  localparam int QW   = (INDEX_FRAC_BITS + 1 > jfi_pkg::SHARE_QW) ?
                        INDEX_FRAC_BITS + 1 : jfi_pkg::SHARE_QW;
  localparam int DCW  = $clog2(QW + 1);

  // ---------------- accumulators ----------------
  logic [CW-1:0]                 count_r, count_nxt;
  logic [SUMW-1:0]               sum_r, sum_nxt;
  logic [jfi_pkg::MAG_W-1:0]     big_r, big_nxt;
  logic [jfi_pkg::ID_W-1:0]      big_id_r, big_id_nxt;
  logic                          ovf_r, ovf_nxt;

  logic                          positive, full, take;
  logic [jfi_pkg::MAG_W-1:0]     x;

  assign positive = !in_flow_bytes[jfi_pkg::BYTES_W-1] && (in_flow_bytes != '0);
  assign x        = in_flow_bytes[jfi_pkg::MAG_W-1:0];
  assign full     = (count_r == CW'(MAX_FLOWS));
  assign take     = cmd.absorb && positive && !full;

  always_comb begin
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    big_nxt    = big_r;
    big_id_nxt = big_id_r;
    ovf_nxt    = ovf_r;
    if (cmd.res_ld) begin
      count_nxt  = '0;
      sum_nxt    = '0;
      big_nxt    = '0;
      big_id_nxt = '0;
      ovf_nxt    = 1'b0;
    end else if (cmd.absorb && positive) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CW'(1);
        sum_nxt   = sum_r + SUMW'(x);
        if (x > big_r) begin
          big_nxt    = x;
          big_id_nxt = in_flow_id;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sum_r    <= '0;
      big_r    <= '0;
      big_id_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
      big_r    <= big_nxt;
      big_id_r <= big_id_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // ---------------- squarer: partial products, then accumulate ----------------
  logic                              pp_vld_r;
  logic [2*jfi_pkg::XL_W-1:0]        pp_ll_r;
  logic [jfi_pkg::XL_W+jfi_pkg::XH_W-1:0] pp_hl_r;
  logic [2*jfi_pkg::XH_W-1:0]        pp_hh_r;
  logic [jfi_pkg::SQS_W-1:0]         sqs_r, sqs_nxt;

  always_ff @(posedge clk) begin
    pp_ll_r <= x[jfi_pkg::XL_W-1:0] * x[jfi_pkg::XL_W-1:0];
    pp_hl_r <= x[jfi_pkg::MAG_W-1:jfi_pkg::XL_W] * x[jfi_pkg::XL_W-1:0];
    pp_hh_r <= x[jfi_pkg::MAG_W-1:jfi_pkg::XL_W] * x[jfi_pkg::MAG_W-1:jfi_pkg::XL_W];
  end

  always_comb begin
    sqs_nxt = sqs_r;
    if (cmd.res_ld) begin
      sqs_nxt = '0;
    end else if (pp_vld_r) begin
      sqs_nxt = sqs_r + jfi_pkg::SQS_W'(pp_ll_r)
              + (jfi_pkg::SQS_W'(pp_hl_r) << (jfi_pkg::XL_W + 1))
              + (jfi_pkg::SQS_W'(pp_hh_r) << (2 * jfi_pkg::XL_W));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_vld_r <= 1'b0;
      sqs_r    <= '0;
    end else begin
      pp_vld_r <= take;
      sqs_r    <= sqs_nxt;
    end
  end

  // ---------------- shift-add multiplier ----------------
  logic [PW-1:0]   mul_a_r, mul_a_nxt;
  logic [SUMW-1:0] mul_b_r, mul_b_nxt;
  logic [PW-1:0]   mul_acc_r, mul_acc_nxt;
  logic [PW-1:0]   den_r;

  always_comb begin
    mul_a_nxt   = mul_a_r;
    mul_b_nxt   = mul_b_r;
    mul_acc_nxt = mul_acc_r;
    if (cmd.mul_ld) begin
      mul_acc_nxt = '0;
      if (cmd.mul_sel == jfi_pkg::MSEL_DEN) begin
        mul_a_nxt = PW'(sqs_r);
        mul_b_nxt = SUMW'(count_r);
      end else begin
        mul_a_nxt = PW'(sum_r);
        mul_b_nxt = sum_r;
      end
    end else if (cmd.mul_step) begin
      if (mul_b_r[0]) mul_acc_nxt = mul_acc_r + mul_a_r;
      mul_a_nxt = mul_a_r << 1;
      mul_b_nxt = mul_b_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    mul_a_r   <= mul_a_nxt;
    mul_b_r   <= mul_b_nxt;
    mul_acc_r <= mul_acc_nxt;
    if (cmd.den_cap) den_r <= mul_acc_r;
  end

  // ---------------- restoring divider ----------------
  // remainder stays below the divisor; numerator low bits shift in MSB first
  logic [PW-1:0]                   rem_r, rem_nxt;
  logic [PW-1:0]                   dvs_r, dvs_nxt;
  logic [QW-1:0]                   nl_r, nl_nxt;
  logic [QW-1:0]                   q_r, q_nxt;
  logic [DCW-1:0]                  dcnt_r, dcnt_nxt;
  logic [QW-1:0]                   idx_r;
  logic [PW:0]                     rem_sh, rem_dif;
  logic                            ge;
  logic [jfi_pkg::MAG_W+6:0]       big100;
  logic [jfi_pkg::SHARE_NW-1:0]    shr_num;

  // hog * 25600 = (hog * 100) << 8, hog * 100 = hog*64 + hog*32 + hog*4
  assign big100  = ((jfi_pkg::MAG_W+7)'(big_r) << 6) + ((jfi_pkg::MAG_W+7)'(big_r) << 5)
                 + ((jfi_pkg::MAG_W+7)'(big_r) << 2);
  assign shr_num = {big100, 8'd0};

  assign rem_sh  = {rem_r, nl_r[QW-1]};
  assign rem_dif = rem_sh - {1'b0, dvs_r};
  assign ge      = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    nl_nxt   = nl_r;
    q_nxt    = q_r;
    dcnt_nxt = dcnt_r;
    if (cmd.div_ld) begin
      q_nxt = '0;
      if (cmd.div_sel == jfi_pkg::DSEL_IDX) begin
        // numerator sum^2 << F, F+1 quotient bits
        rem_nxt  = mul_acc_r >> 1;
        dvs_nxt  = den_r;
        nl_nxt   = QW'(mul_acc_r[0]) << (QW - 1);
        dcnt_nxt = DCW'(INDEX_FRAC_BITS + 1);
      end else begin
        rem_nxt  = PW'(shr_num >> jfi_pkg::SHARE_QW);
        dvs_nxt  = PW'(sum_r);
        nl_nxt   = QW'(shr_num[jfi_pkg::SHARE_QW-1:0]) << (QW - jfi_pkg::SHARE_QW);
        dcnt_nxt = DCW'(jfi_pkg::SHARE_QW);
      end
    end else if (cmd.div_step) begin
      rem_nxt  = ge ? rem_dif[PW-1:0] : rem_sh[PW-1:0];
      nl_nxt   = nl_r << 1;
      q_nxt    = {q_r[QW-2:0], ge};
      dcnt_nxt = dcnt_r - DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else begin
      dcnt_r <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    nl_r  <= nl_nxt;
    q_r   <= q_nxt;
    if (cmd.idx_cap) idx_r <= q_r;
  end

  // ---------------- result register ----------------
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_ld) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      if (count_r == '0) begin
        out_flow_count     <= '0;
        out_fairness_index <= '0;
        out_peak_bytes     <= '0;
        out_hog_flow       <= '0;
        out_hog_share      <= '0;
        out_too_many_flows <= 1'b0;
      end else begin
        out_flow_count     <= jfi_pkg::COUNT_W'(count_r);
        out_fairness_index <= jfi_pkg::INDEX_W'(idx_r);
        out_peak_bytes     <= big_r;
        out_hog_flow       <= big_id_r;
        out_hog_share      <= jfi_pkg::SHARE_W'(q_r);
        out_too_many_flows <= ovf_r;
      end
    end
  end

  assign out_valid = out_valid_r;

  assign sts.count_zero = (count_r == '0);
  assign sts.mul_done   = (mul_b_r == '0);
  assign sts.div_done   = (dcnt_r == '0);
  assign sts.out_busy   = out_valid_r && !out_ready;

`ifndef SYNTH
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_FLOWS))
    else $error("flow count above capacity");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.idx_cap |-> (q_r <= (QW'(1) << INDEX_FRAC_BITS)))
    else $error("fairness quotient above one");

  a_share_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_ld && (count_r != '0)) |-> (q_r <= QW'(25600)))
    else $error("hog share above 100 percent");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for jain_fairness_index_core. Streams sets of flows
// into the core and scores every report against a local predictor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int BYTES_W = jfi_pkg::BYTES_W;
  localparam int MAG_W   = jfi_pkg::MAG_W;
  localparam int ID_W    = jfi_pkg::ID_W;
  localparam int COUNT_W = jfi_pkg::COUNT_W;
  localparam int INDEX_W = jfi_pkg::INDEX_W;
  localparam int SHARE_W = jfi_pkg::SHARE_W;

  localparam int MAX_FLOWS   = 4096;
  localparam int FRAC_BITS   = 16;
  localparam int RAND_ITEMS  = 480;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 200;      // longer than one full report pass
  localparam int LONG_HOLD   = 400;      // receiver hold-off, in cycles
  localparam logic [MAG_W-1:0]   BYTES_MAX = {MAG_W{1'b1}};
  localparam logic [BYTES_W-1:0] BYTES_MIN = {1'b1, {MAG_W{1'b0}}};
  localparam logic [BYTES_W-1:0] MINUS_ONE = {BYTES_W{1'b1}};

  // one pending flow; drain_first makes the driver wait until every
  // outstanding report has been taken before it offers this flow
  typedef struct {
    logic [BYTES_W-1:0] bytes;
    logic [ID_W-1:0]    id;
    logic               last;
    bit                 drain_first;
  } flow_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [INDEX_W-1:0] index;
    logic [MAG_W-1:0]   peak_bytes;
    logic [ID_W-1:0]    hog_id;
    logic [SHARE_W-1:0] share;
    logic               overflow;
  } report_t;

  // --------------------------------------------------------------------------
  // clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [BYTES_W-1:0] in_flow_bytes = '0;
  logic [ID_W-1:0]    in_flow_id    = '0;
  logic               in_last_flow  = 1'b0;

  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [COUNT_W-1:0] out_flow_count;
  logic [INDEX_W-1:0] out_fairness_index;
  logic [MAG_W-1:0]   out_peak_bytes;
  logic [ID_W-1:0]    out_hog_flow;
  logic [SHARE_W-1:0] out_hog_share;
  logic               out_too_many_flows;

  initial begin
    forever #1 clk = ~clk;
  end

  // single synchronous reset pulse
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  jain_fairness_index_core #(
    .MAX_FLOWS       (MAX_FLOWS),
    .INDEX_FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_flow_bytes      (in_flow_bytes),
    .in_flow_id         (in_flow_id),
    .in_last_flow       (in_last_flow),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_flow_count     (out_flow_count),
    .out_fairness_index (out_fairness_index),
    .out_peak_bytes     (out_peak_bytes),
    .out_hog_flow       (out_hog_flow),
    .out_hog_share      (out_hog_share),
    .out_too_many_flows (out_too_many_flows)
  );

  // --------------------------------------------------------------------------
  // fairness predictor
  // Running totals of the current set; a last flow closes the set, pushes
  // the predicted report and clears the totals.
  // --------------------------------------------------------------------------
  flow_t   flow_q[$];     // flows not yet offered
  report_t report_q[$];   // predicted reports, oldest first

  logic [31:0]      acc_count      = '0;
  logic [63:0]      acc_sum        = '0;
  logic [95:0]      acc_sq         = '0;   // sum of squares, wraps mod 2^96
  logic [MAG_W-1:0] acc_peak_bytes = '0;
  logic [ID_W-1:0]  acc_hog_id     = '0;
  logic             acc_over       = 1'b0;

  int fail_cnt     = 0;
  int reports_seen = 0;

  task automatic absorb_flow(input logic [BYTES_W-1:0] b, input logic [ID_W-1:0] id,
                             input logic last);
    logic [MAG_W-1:0] x;
    logic [191:0]     wide_sum;
    logic [191:0]     num;
    logic [191:0]     den;
    logic [191:0]     quo;
    logic [63:0]      share;
    report_t          r;
    x = b[MAG_W-1:0];
    // zero and negative flows are skipped entirely, capacity included
    if (!b[BYTES_W-1] && b != '0) begin
      if (acc_count >= MAX_FLOWS) begin
        acc_over = 1'b1;
      end else begin
        acc_count++;
        acc_sum += {24'b0, x};
        acc_sq  += {56'b0, x} * {56'b0, x};
        if (x > acc_peak_bytes) begin  // strict compare: first seen wins ties
          acc_peak_bytes = x;
          acc_hog_id     = id;
        end
      end
    end
    if (last) begin
      r = '0;                          // empty set reports all zeros
      if (acc_count != 0) begin
        wide_sum     = {128'b0, acc_sum};
        num          = (wide_sum * wide_sum) << FRAC_BITS;
        den          = {160'b0, acc_count} * {96'b0, acc_sq};
        quo          = num / den;
        share        = ({24'b0, acc_peak_bytes} * 64'd25600) / acc_sum;
        r.count      = acc_count[COUNT_W-1:0];
        r.index      = quo[INDEX_W-1:0];
        r.peak_bytes = acc_peak_bytes;
        r.hog_id     = acc_hog_id;
        r.share      = share[SHARE_W-1:0];
        r.overflow   = acc_over;
      end
      report_q.push_back(r);
      acc_count      = '0;
      acc_sum        = '0;
      acc_sq         = '0;
      acc_peak_bytes = '0;
      acc_hog_id     = '0;
      acc_over       = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  // --------------------------------------------------------------------------
  // monitor
  // Samples both channels at the clock edge. Input transactions feed the
  // predictor; each output transaction is scored against the oldest report.
  // --------------------------------------------------------------------------
  report_t exp_r;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        absorb_flow(in_flow_bytes, in_flow_id, in_last_flow);
      end
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $error("report transaction with no prediction pending");
          fail_cnt++;
        end else begin
          exp_r = report_q.pop_front();
          check_field("flow_count",     exp_r.count,      out_flow_count);
          check_field("fairness_index", exp_r.index,      out_fairness_index);
          check_field("peak_bytes",     exp_r.peak_bytes, out_peak_bytes);
          check_field("hog_flow",       exp_r.hog_id,     out_hog_flow);
          check_field("hog_share",      exp_r.share,      out_hog_share);
          check_field("too_many_flows", exp_r.overflow,   out_too_many_flows);
        end
        reports_seen <= reports_seen + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // driver
  // Offers flows in bursts of random length separated by random gaps. A
  // payload is held until its transaction completes. A flow marked
  // drain_first waits for an idle output side before it goes out.
  // --------------------------------------------------------------------------
  int    burst_left = 0;
  int    gap_left   = 0;
  flow_t drv_flow;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (flow_q.size() == 0 ||
                   (flow_q[0].drain_first && (in_valid || report_q.size() != 0))) begin
        in_valid <= 1'b0;
      end else begin
        drv_flow      = flow_q.pop_front();
        in_flow_bytes <= drv_flow.bytes;
        in_flow_id    <= drv_flow.id;
        in_last_flow  <= drv_flow.last;
        in_valid      <= 1'b1;
        if (burst_left <= 1) begin
          // mostly short bursts, now and then a long gap-free run
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver
  // Random short stalls, calm windows with none, and two long hold-offs
  // that let a finished report back up and stall the next last flow.
  // --------------------------------------------------------------------------
  int   stall_left = 0;
  int   hold_left  = 0;
  int   holds_done = 0;
  int   next_hold  = 12;
  logic [11:0] rx_tick = '0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (reports_seen == next_hold && holds_done < 2) begin
      out_ready  <= 1'b0;
      hold_left  <= LONG_HOLD;
      next_hold  <= next_hold + 25;
      holds_done <= holds_done + 1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (rx_tick[11:10] != 2'b11 && $urandom_range(0, 3) == 0) begin
        stall_left <= $urandom_range(1, 24);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  logic [BYTES_W-1:0] prev_bytes = '0;
  int                 rand_cnt   = 0;

  task automatic push_flow(input logic [BYTES_W-1:0] b, input logic [ID_W-1:0] id,
                           input logic last, input bit drain);
    flow_t f;
    f.bytes       = b;
    f.id          = id;
    f.last        = last;
    f.drain_first = drain;
    flow_q.push_back(f);
    prev_bytes = b;
  endtask

  // byte count mix: full-range noise, small, medium, max, zero, negative,
  // repeats of the previous value (ties) and large positive
  function automatic logic [BYTES_W-1:0] rand_bytes();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0, 1:    return r[BYTES_W-1:0];
      2:       return {31'b0, r[9:0]} + 41'd1;
      3:       return {21'b0, r[19:0]};
      4:       return {1'b0, BYTES_MAX};
      5:       return '0;
      6:       return {1'b1, r[MAG_W-1:0]};
      7:       return prev_bytes;
      default: return {1'b0, r[MAG_W-1:0]};
    endcase
  endfunction

  initial begin
    int len;
    int pick;

    // ---- directed sets ----
    push_flow('0, 16'h0000, 1'b1, 1'b0);                 // empty set, zero flow
    push_flow(BYTES_MIN, 16'hFFFF, 1'b1, 1'b0);          // only the most negative
    push_flow({1'b0, BYTES_MAX}, 16'hFFFF, 1'b1, 1'b1);  // one max flow, after a drain
    // tie on the largest flow: the first id must win
    push_flow(41'd100, 16'd7, 1'b0, 1'b0);
    push_flow(41'd100, 16'd3, 1'b0, 1'b0);
    push_flow(41'd50,  16'd9, 1'b1, 1'b0);
    // skipped flows in between, very unfair spread
    push_flow(41'd5, 16'd1, 1'b0, 1'b0);
    push_flow('0, 16'd2, 1'b0, 1'b0);
    push_flow(MINUS_ONE, 16'd3, 1'b0, 1'b0);
    push_flow(BYTES_MIN, 16'd4, 1'b0, 1'b0);
    push_flow(41'd1, 16'd5, 1'b0, 1'b0);
    push_flow({1'b0, BYTES_MAX}, 16'd6, 1'b0, 1'b0);
    push_flow(41'd1, 16'd0, 1'b1, 1'b0);
    // last flow itself skipped
    push_flow(41'd10, 16'd11, 1'b0, 1'b0);
    push_flow(41'd20, 16'd12, 1'b0, 1'b0);
    push_flow(MINUS_ONE, 16'd13, 1'b1, 1'b0);

    // ---- random sets ----
    while (rand_cnt < RAND_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)      len = 0;
      else if (pick == 1) len = $urandom_range(20, 60);
      else                len = $urandom_range(1, 10);
      for (int i = 0; i <= len; i++) begin
        push_flow(rand_bytes(), 16'($urandom_range(0, 65535)), (i == len),
                  (i == 0) && ($urandom_range(0, 11) == 0));
      end
      rand_cnt += len + 1;
    end

    // ---- wind down ----
    wait (rst_n);
    while (flow_q.size() != 0 || in_valid) @(posedge clk);
    while (report_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (report_q.size() != 0) begin
      $error("%0d predicted reports never arrived", report_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("status: fail");
    $finish;
  end

endmodule
